// File: hw/rtl/bitmap_block_allocator_macros.svh
// Assertion macros used by the checker module of the block allocator.
`ifndef BITMAP_BLOCK_ALLOCATOR_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define BBA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is asserted.
`define BBA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked across reset.
`define BBA_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/bba_pkg.sv
// Package of the bitmap block allocator: types, codes and default sizes.
`default_nettype none

package bba_pkg;

    localparam int NUM_BLOCKS_DEF       = 32768;
    localparam int WORD_BITS_DEF        = 32;
    localparam int BLOCK_BYTES_LOG2_DEF = 12;

    localparam int ADDR_W      = 32;
    localparam int LEN_W       = 32;
    localparam int COUNT_OUT_W = 16;
    // Wide enough for a bit position in the widest bitmap word (64 bits).
    localparam int BIT_IDX_W   = 6;

    localparam logic [ADDR_W-1:0] ADDR_MASK = 32'hffff_ffff;

    typedef enum logic [1:0] {
        KIND_ALLOC   = 2'd0,
        KIND_FREE    = 2'd1,
        KIND_RESERVE = 2'd2,
        KIND_RELEASE = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_FREE  = 2'd1,
        ST_BAD_FREE = 2'd2
    } t_status;

    typedef struct packed {
        t_kind              kind;
        logic [ADDR_W-1:0]  address;
        logic [LEN_W-1:0]   length;
    } t_req;

    typedef struct packed {
        logic [ADDR_W-1:0]      block_address;
        t_status                status;
        logic [COUNT_OUT_W-1:0] free_blocks;
    } t_rsp;

    // Control of the shared word unit for one read-modify-write of a bitmap word.
    typedef struct packed {
        logic                 lowest;  // pick the lowest clear bit instead of lo..hi
        logic                 set;     // 1 marks bits used, 0 marks them free
        logic [BIT_IDX_W-1:0] lo;
        logic [BIT_IDX_W-1:0] hi;
    } t_unit_ctl;

endpackage

`default_nettype wire

// File: hw/rtl/bba_bitmap_ram.sv
// Single-port-write, registered-read memory holding the usage bitmap words.
`default_nettype none

module bba_bitmap_ram #(
    parameter int WORD_BITS = bba_pkg::WORD_BITS_DEF,
    parameter int DEPTH     = bba_pkg::NUM_BLOCKS_DEF / bba_pkg::WORD_BITS_DEF,
    parameter int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [AW-1:0]        i_waddr,
    input  wire logic [WORD_BITS-1:0] i_wdata,
    input  wire logic [AW-1:0]        i_raddr,
    output logic      [WORD_BITS-1:0] o_rdata
);

    logic [WORD_BITS-1:0] r_mem [DEPTH];
    logic [WORD_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: hw/rtl/bba_word_unit.sv
// Shared word unit: builds the bit mask for one bitmap word and applies it.
`default_nettype none

module bba_word_unit
    import bba_pkg::*;
#(
    parameter int WORD_BITS = bba_pkg::WORD_BITS_DEF,
    parameter int OB        = $clog2(WORD_BITS)
) (
    input  wire logic [WORD_BITS-1:0] i_word,
    input  wire t_unit_ctl            i_ctl,
    output logic      [WORD_BITS-1:0] o_word,
    output logic      [WORD_BITS-1:0] o_flip,
    output logic                      o_full,
    output logic      [OB-1:0]        o_index
);

    localparam logic [WORD_BITS-1:0] ONES   = {WORD_BITS{1'b1}};
    localparam logic [OB-1:0]        TOP_IX = OB'(WORD_BITS - 1);

    logic [OB-1:0]        lo;
    logic [OB-1:0]        hi;
    logic [WORD_BITS-1:0] mask;

    assign lo = i_ctl.lo[OB-1:0];
    assign hi = i_ctl.hi[OB-1:0];

    always_comb begin
        if (i_ctl.lowest) begin
            // The lowest clear bit, alone: zero when the word is full.
            mask = ~i_word & (i_word + {{(WORD_BITS-1){1'b0}}, 1'b1});
        end else begin
            mask = (ONES << lo) & (ONES >> (TOP_IX - hi));
        end
    end

    always_comb begin
        o_index = '0;
        for (int j = 0; j < WORD_BITS; j++) begin
            if (mask[j]) begin
                o_index = o_index | OB'(j);
            end
        end
    end

    assign o_full = &i_word;
    assign o_word = i_ctl.set ? (i_word | mask) : (i_word & ~mask);
    assign o_flip = i_ctl.set ? (mask & ~i_word) : (mask & i_word);

endmodule

`default_nettype wire

// File: hw/rtl/bitmap_block_allocator.sv
// Top level of the first-fit bitmap block allocator.
`default_nettype none

// First-fit block allocator over a usage bitmap (one bit per block, 1 = used)
// held in an on-chip memory of NUM_BLOCKS/WORD_BITS words, with a free-block
// count beside it. Request items select allocate, free one block, reserve a
// byte range (length rounded up to whole blocks) or release a byte range
// (length rounded down, block 0 then forced back to used). Every request item
// yields exactly one response item with the allocated address, a status and
// the free count after the operation. Out-of-range and double frees report a
// bad-free status and change nothing. After reset the block runs a clearing
// pass that writes every bitmap word to all-used, one word a cycle, so it
// accepts no request until the pass is through. Requests are handled one at
// a time; the bitmap memory has one read and one write port and every word
// visited passes through a read state and a modify-write state in the shared
// word unit. Allocate scans upward from a hint below which every word is
// known to be full, and scans nothing when no block is free; an out-of-range
// free visits no word; reserve visits every bitmap word the range touches,
// and release does the same and then visits word 0 to force block 0 used.
// A new request item is accepted while a response item still waits to be
// taken. NUM_BLOCKS and WORD_BITS are expected to be powers of two.
module bitmap_block_allocator
    import bba_pkg::*;
#(
    parameter int NUM_BLOCKS       = NUM_BLOCKS_DEF,
    parameter int WORD_BITS        = WORD_BITS_DEF,
    parameter int BLOCK_BYTES_LOG2 = BLOCK_BYTES_LOG2_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_req i_in_req,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_rsp      o_out_rsp
);

    localparam int MAP_WORDS = NUM_BLOCKS / WORD_BITS;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int OB        = $clog2(WORD_BITS);
    localparam int BW        = AW + OB;
    localparam int FW        = ADDR_W - BLOCK_BYTES_LOG2;
    localparam int EW        = ((FW > BW) ? FW : BW) + 2;
    localparam int CW        = $clog2(NUM_BLOCKS + 1);

    localparam logic [EW-1:0]        NB_E      = EW'(NUM_BLOCKS);
    localparam logic [AW-1:0]        LAST_WORD = AW'(MAP_WORDS - 1);
    localparam logic [OB-1:0]        TOP_IX    = OB'(WORD_BITS - 1);
    localparam logic [WORD_BITS-1:0] ALL_USED  = {WORD_BITS{1'b1}};

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_PREP,
        S_BOUND,
        S_READ,
        S_MODIFY,
        S_DONE
    } t_state;

    // What the current word pass does.
    typedef enum logic [1:0] {
        OP_ALLOC,
        OP_FREE,
        OP_RANGE,
        OP_FORCE0
    } t_op;

    t_state               r_state,    n_state;
    t_op                  r_op,       n_op;
    t_req                 r_req,      n_req;
    logic                 r_set,      n_set;
    logic [EW-1:0]        r_end,      n_end;
    logic [AW-1:0]        r_widx,     n_widx;
    logic [AW-1:0]        r_wfirst,   n_wfirst;
    logic [AW-1:0]        r_wlast,    n_wlast;
    logic [OB-1:0]        r_lo,       n_lo;
    logic [OB-1:0]        r_hi,       n_hi;
    logic [AW-1:0]        r_hint,     n_hint;
    logic [CW-1:0]        r_count,    n_count;
    logic [WORD_BITS-1:0] r_flip,     n_flip;
    logic                 r_flip_set, n_flip_set;
    logic                 r_flip_vld, n_flip_vld;
    t_status              r_status,   n_status;
    logic [ADDR_W-1:0]    r_baddr,    n_baddr;
    logic                 r_out_vld,  n_out_vld;
    t_rsp                 r_rsp,      n_rsp;

    // Memory and word unit connections.
    logic                 mem_we;
    logic [WORD_BITS-1:0] mem_wdata;
    logic [WORD_BITS-1:0] mem_rdata;
    t_unit_ctl            u_ctl;
    logic [WORD_BITS-1:0] u_word;
    logic [WORD_BITS-1:0] u_flip;
    logic                 u_full;
    logic [OB-1:0]        u_index;

    // Range arithmetic on the registered request.
    logic [EW-1:0]        first_e;
    logic [EW-1:0]        nblk_e;
    logic [EW-1:0]        end_e;
    logic [EW-1:0]        last_e;
    logic                 round_up;
    logic [BW-1:0]        blk;
    logic [63:0]          blk_addr;
    logic [OB:0]          flip_pop;

    function automatic logic [OB:0] f_popcount(input logic [WORD_BITS-1:0] v);
        logic [OB:0] acc;
        acc = '0;
        for (int j = 0; j < WORD_BITS; j++) begin
            acc = acc + {{OB{1'b0}}, v[j]};
        end
        return acc;
    endfunction

    bba_bitmap_ram #(
        .WORD_BITS (WORD_BITS),
        .DEPTH     (MAP_WORDS),
        .AW        (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_widx),
        .i_wdata (mem_wdata),
        .i_raddr (r_widx),
        .o_rdata (mem_rdata)
    );

    bba_word_unit #(
        .WORD_BITS (WORD_BITS),
        .OB        (OB)
    ) u_unit (
        .i_word  (mem_rdata),
        .i_ctl   (u_ctl),
        .o_word  (u_word),
        .o_flip  (u_flip),
        .o_full  (u_full),
        .o_index (u_index)
    );

    assign first_e  = EW'(r_req.address[ADDR_W-1:BLOCK_BYTES_LOG2]);
    assign round_up = (r_req.kind == KIND_RESERVE) && (|r_req.length[BLOCK_BYTES_LOG2-1:0]);
    assign nblk_e   = EW'(r_req.length[LEN_W-1:BLOCK_BYTES_LOG2]) + EW'(round_up);
    assign end_e    = first_e + nblk_e;
    assign last_e   = r_end - EW'(1);
    assign blk      = {r_widx, u_index};
    assign blk_addr = 64'(blk) << BLOCK_BYTES_LOG2;
    assign flip_pop = f_popcount(r_flip);

    // Word unit control for the word at r_widx.
    always_comb begin
        u_ctl        = '0;
        u_ctl.lowest = (r_op == OP_ALLOC);
        case (r_op)
            OP_ALLOC: begin
                u_ctl.set = 1'b1;
            end
            OP_FREE: begin
                u_ctl.set = 1'b0;
                u_ctl.lo  = BIT_IDX_W'(r_lo);
                u_ctl.hi  = BIT_IDX_W'(r_lo);
            end
            OP_RANGE: begin
                u_ctl.set = r_set;
                u_ctl.lo  = (r_widx == r_wfirst) ? BIT_IDX_W'(r_lo) : '0;
                u_ctl.hi  = (r_widx == r_wlast) ? BIT_IDX_W'(r_hi) : BIT_IDX_W'(TOP_IX);
            end
            OP_FORCE0: begin
                u_ctl.set = 1'b1;
            end
            default: begin
                u_ctl.set = 1'b1;
            end
        endcase
    end

    // The count follows each modified word in the cycle after it is written.
    always_comb begin
        n_count = r_count;
        if (r_flip_vld) begin
            if (r_flip_set) begin
                n_count = r_count - CW'(flip_pop);
            end else begin
                n_count = r_count + CW'(flip_pop);
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_req      = r_req;
        n_set      = r_set;
        n_end      = r_end;
        n_widx     = r_widx;
        n_wfirst   = r_wfirst;
        n_wlast    = r_wlast;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_hint     = r_hint;
        n_flip     = r_flip;
        n_flip_set = r_flip_set;
        n_flip_vld = 1'b0;
        n_status   = r_status;
        n_baddr    = r_baddr;
        n_rsp      = r_rsp;
        n_out_vld  = r_out_vld && !i_out_ready;
        mem_we     = 1'b0;
        mem_wdata  = u_word;

        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_wdata = ALL_USED;
                if (r_widx == LAST_WORD) begin
                    n_widx  = '0;
                    n_state = S_IDLE;
                end else begin
                    n_widx = r_widx + AW'(1);
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req    = i_in_req;
                    n_status = ST_OK;
                    n_baddr  = '0;
                    n_state  = S_PREP;
                end
            end
            S_PREP: begin
                case (r_req.kind)
                    KIND_ALLOC: begin
                        n_op = OP_ALLOC;
                        if (r_count == '0) begin
                            n_status = ST_NO_FREE;
                            n_state  = S_DONE;
                        end else begin
                            n_widx  = r_hint;
                            n_state = S_READ;
                        end
                    end
                    KIND_FREE: begin
                        n_op = OP_FREE;
                        if (first_e >= NB_E) begin
                            n_status = ST_BAD_FREE;
                            n_state  = S_DONE;
                        end else begin
                            n_widx  = first_e[BW-1:OB];
                            n_lo    = first_e[OB-1:0];
                            n_state = S_READ;
                        end
                    end
                    default: begin
                        n_op    = OP_RANGE;
                        n_set   = (r_req.kind == KIND_RESERVE);
                        n_end   = (end_e > NB_E) ? NB_E : end_e;
                        n_state = S_BOUND;
                    end
                endcase
            end
            S_BOUND: begin
                if (first_e >= r_end) begin
                    // Empty range: only a release still forces block 0 used.
                    if (r_set) begin
                        n_state = S_DONE;
                    end else begin
                        n_op    = OP_FORCE0;
                        n_widx  = '0;
                        n_state = S_READ;
                    end
                end else begin
                    n_widx   = first_e[BW-1:OB];
                    n_wfirst = first_e[BW-1:OB];
                    n_lo     = first_e[OB-1:0];
                    n_wlast  = last_e[BW-1:OB];
                    n_hi     = last_e[OB-1:0];
                    n_state  = S_READ;
                end
            end
            S_READ: begin
                n_state = S_MODIFY;
            end
            S_MODIFY: begin
                n_flip     = u_flip;
                n_flip_set = u_ctl.set;
                case (r_op)
                    OP_ALLOC: begin
                        if (u_full) begin
                            if (r_widx == LAST_WORD) begin
                                n_status = ST_NO_FREE;
                                n_state  = S_DONE;
                            end else begin
                                n_widx  = r_widx + AW'(1);
                                n_state = S_READ;
                            end
                        end else begin
                            mem_we     = 1'b1;
                            n_flip_vld = 1'b1;
                            n_baddr    = blk_addr[ADDR_W-1:0] & ADDR_MASK;
                            n_hint     = r_widx;
                            n_state    = S_DONE;
                        end
                    end
                    OP_FREE: begin
                        if (u_flip == '0) begin
                            n_status = ST_BAD_FREE;
                        end else begin
                            mem_we     = 1'b1;
                            n_flip_vld = 1'b1;
                            if (r_widx < r_hint) begin
                                n_hint = r_widx;
                            end
                        end
                        n_state = S_DONE;
                    end
                    OP_RANGE: begin
                        mem_we     = 1'b1;
                        n_flip_vld = 1'b1;
                        if (!r_set && (u_flip != '0) && (r_widx < r_hint)) begin
                            n_hint = r_widx;
                        end
                        if (r_widx == r_wlast) begin
                            if (r_set) begin
                                n_state = S_DONE;
                            end else begin
                                n_op    = OP_FORCE0;
                                n_widx  = '0;
                                n_state = S_READ;
                            end
                        end else begin
                            n_widx  = r_widx + AW'(1);
                            n_state = S_READ;
                        end
                    end
                    default: begin
                        mem_we     = 1'b1;
                        n_flip_vld = 1'b1;
                        n_state    = S_DONE;
                    end
                endcase
            end
            S_DONE: begin
                if (!r_out_vld || i_out_ready) begin
                    n_rsp.block_address = r_baddr;
                    n_rsp.status        = r_status;
                    n_rsp.free_blocks   = COUNT_OUT_W'(n_count);
                    n_out_vld           = 1'b1;
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_op       <= OP_ALLOC;
            r_widx     <= '0;
            r_hint     <= '0;
            r_count    <= '0;
            r_flip_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_op       <= n_op;
            r_widx     <= n_widx;
            r_hint     <= n_hint;
            r_count    <= n_count;
            r_flip_vld <= n_flip_vld;
            r_out_vld  <= n_out_vld;
        end
        r_req      <= n_req;
        r_set      <= n_set;
        r_end      <= n_end;
        r_wfirst   <= n_wfirst;
        r_wlast    <= n_wlast;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_flip     <= n_flip;
        r_flip_set <= n_flip_set;
        r_status   <= n_status;
        r_baddr    <= n_baddr;
        r_rsp      <= n_rsp;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_rsp   = r_rsp;

endmodule

`default_nettype wire

// File: hw/rtl/bba_checker.sv
// Port-level checker of the bitmap block allocator and its bind statement.
`default_nettype none

`include "bitmap_block_allocator_macros.svh"

module bba_checker
    import bba_pkg::*;
#(
    parameter int BLOCK_BYTES_LOG2 = BLOCK_BYTES_LOG2_DEF
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic o_in_ready,
    input wire logic o_out_valid,
    input wire logic i_out_ready,
    input wire t_rsp o_out_rsp
);

    // A response item waiting to be taken stays offered.
    `BBA_ASSERT_NXT(a_out_hold, i_clk, i_rst_n,
        o_out_valid && !i_out_ready, o_out_valid,
        "response item dropped while stalled")

    // The clearing pass follows reset, so no request item is taken just after it.
    `BBA_ASSERT_NXT_ALWAYS(a_clear_after_reset, i_clk, !i_rst_n, !o_in_ready,
        "request accepted during clearing pass")

    // Only a successful allocation carries an address.
    `BBA_ASSERT_IMP(a_addr_only_ok, i_clk, i_rst_n,
        o_out_valid && (o_out_rsp.status != ST_OK), o_out_rsp.block_address == '0,
        "address given with failing status")

    // Allocated addresses fall on block boundaries.
    `BBA_ASSERT_IMP(a_addr_aligned, i_clk, i_rst_n,
        o_out_valid, o_out_rsp.block_address[BLOCK_BYTES_LOG2-1:0] == '0,
        "unaligned block address")

    // Exhaustion is reported only with no free blocks left.
    `BBA_ASSERT_IMP(a_exhaust_count, i_clk, i_rst_n,
        o_out_valid && (o_out_rsp.status == ST_NO_FREE), o_out_rsp.free_blocks == '0,
        "exhaustion with free blocks counted")

endmodule

bind bitmap_block_allocator bba_checker #(
    .BLOCK_BYTES_LOG2 (BLOCK_BYTES_LOG2)
) u_bba_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_rsp   (o_out_rsp)
);

`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench for the first-fit bitmap block allocator.
module testbench;
    import bba_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD       = 2;
    localparam int NUM_BLOCKS       = NUM_BLOCKS_DEF;
    localparam int WORD_BITS        = WORD_BITS_DEF;
    localparam int BLOCK_BYTES_LOG2 = BLOCK_BYTES_LOG2_DEF;
    localparam int MAP_WORDS        = NUM_BLOCKS / WORD_BITS;
    localparam int BLOCK_BYTES      = 1 << BLOCK_BYTES_LOG2;

    // Most random traffic stays in the low blocks so that scans stay short.
    localparam int ACTIVE_BLOCKS = 1024;
    localparam int RANDOM_ITEMS  = 1300;
    localparam int MAX_GAP       = 12;
    localparam int MAX_STALL     = 24;
    localparam int MAX_REPORTS   = 200;

    // Worst case per item: a scan or range over every bitmap word, the longest
    // sender gap and the longest receiver stall. The clearing pass after reset
    // is added once, and the whole taken four times over.
    localparam int MAX_ITEMS     = 1400;
    localparam int SLOWEST_ITEM  = 2 * MAP_WORDS + 8 + MAX_GAP + MAX_STALL;
    localparam int LIMIT_CYCLES  = 4 * (MAP_WORDS + MAX_ITEMS * SLOWEST_ITEM);
    localparam int SETTLE_CYCLES = 2 * MAP_WORDS + 16;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    t_req in_req    = '0;
    logic out_ready = 1'b0;
    logic in_ready;
    logic out_valid;
    t_rsp out_rsp;

    // Shadow copy of the allocator state, updated as each item is accepted.
    logic [WORD_BITS-1:0] shadow_map [MAP_WORDS];
    int unsigned          shadow_free;

    t_rsp        pending_responses [$];
    logic [31:0] allocated_addrs [$];
    t_rsp        last_outcome;
    int unsigned items_sent     = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;

    // Sender burst state; valid_held mirrors what in_valid will be.
    int unsigned burst_left = 0;
    bit          valid_held = 1'b0;

    // Receiver stall state.
    int unsigned stall_left = 0;
    int unsigned stall_pct  = 0;
    int unsigned style_left = 0;

    bitmap_block_allocator #(
        .NUM_BLOCKS      (NUM_BLOCKS),
        .WORD_BITS       (WORD_BITS),
        .BLOCK_BYTES_LOG2(BLOCK_BYTES_LOG2)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_req   (in_req),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_rsp  (out_rsp)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic bit block_is_used(int unsigned blk);
        return shadow_map[blk / WORD_BITS][blk % WORD_BITS];
    endfunction

    // Only a bit that actually flips moves the free count.
    function automatic void set_block_state(int unsigned blk, bit used);
        if (block_is_used(blk) != used) begin
            shadow_map[blk / WORD_BITS][blk % WORD_BITS] = used;
            if (used) begin
                shadow_free--;
            end else begin
                shadow_free++;
            end
        end
    endfunction

    // Applies one request item to the shadow state and returns the response
    // item the allocator must give for it.
    function automatic t_rsp apply_request(t_req req);
        t_rsp            rsp;
        longint unsigned first_blk;
        longint unsigned span;
        longint unsigned stop_blk;
        longint unsigned b;
        int unsigned     w;
        int unsigned     j;
        bit              found;

        rsp.block_address = '0;
        rsp.status        = ST_OK;
        first_blk         = req.address >> BLOCK_BYTES_LOG2;
        found             = 1'b0;

        case (req.kind)
            KIND_ALLOC: begin
                // Lowest clear bit wins; with a zero count no scan is made.
                if (shadow_free != 0) begin
                    for (w = 0; w < MAP_WORDS && !found; w++) begin
                        if (shadow_map[w] != '1) begin
                            for (j = 0; j < WORD_BITS && !found; j++) begin
                                if (!shadow_map[w][j]) begin
                                    found = 1'b1;
                                    set_block_state(w * WORD_BITS + j, 1'b1);
                                    b = w * WORD_BITS + j;
                                    rsp.block_address = ADDR_W'(b << BLOCK_BYTES_LOG2);
                                end
                            end
                        end
                    end
                end
                if (!found) begin
                    rsp.status = ST_NO_FREE;
                end
            end
            KIND_FREE: begin
                if (first_blk >= NUM_BLOCKS || !block_is_used(int'(first_blk))) begin
                    rsp.status = ST_BAD_FREE;
                end else begin
                    set_block_state(int'(first_blk), 1'b0);
                end
            end
            default: begin
                // Reserve rounds a partial block up, release rounds it down.
                span = req.length >> BLOCK_BYTES_LOG2;
                if (req.kind == KIND_RESERVE && req.length[BLOCK_BYTES_LOG2-1:0] != 0) begin
                    span++;
                end
                stop_blk = first_blk + span;
                if (stop_blk > NUM_BLOCKS) begin
                    stop_blk = NUM_BLOCKS;
                end
                for (b = first_blk; b < stop_blk; b++) begin
                    set_block_state(int'(b), req.kind == KIND_RESERVE);
                end
                if (req.kind == KIND_RELEASE) begin
                    set_block_state(0, 1'b1);
                end
            end
        endcase

        rsp.free_blocks = shadow_free[COUNT_OUT_W-1:0];
        return rsp;
    endfunction

    // ------------------------------------------------------------------
    // Driving and checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("[%0t] %s", $realtime, what);
        end
    endtask

    // Offers one request item and holds it until accepted. Afterwards the
    // sender either carries on with its burst or drops valid for a random gap.
    task automatic send_request(input t_kind kind, input logic [31:0] addr,
                                input logic [31:0] len);
        t_req req;
        int unsigned gap;

        req.kind    = kind;
        req.address = addr;
        req.length  = len;
        in_valid   <= 1'b1;
        in_req     <= req;
        valid_held  = 1'b1;
        do begin
            @(posedge clk);
        end while (!in_ready);

        last_outcome = apply_request(req);
        pending_responses.push_back(last_outcome);
        items_sent++;

        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(0, MAX_GAP);
            if (gap > 0) begin
                in_valid  <= 1'b0;
                valid_held = 1'b0;
                repeat (gap) @(posedge clk);
            end
            // Now and then a long stretch with no idling at all.
            burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(0, 15);
        end
    endtask

    // Stops sending until every outstanding response item has come back.
    task automatic wait_for_responses();
        if (valid_held) begin
            in_valid  <= 1'b0;
            valid_held = 1'b0;
        end
        while (pending_responses.size() != 0) begin
            @(posedge clk);
        end
    endtask

    // Each accepted response item is held against the oldest prediction.
    always @(posedge clk) begin
        t_rsp want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_responses.size() == 0) begin
                report_mismatch($sformatf("response with none pending: addr %h status %0d count %0d",
                                          out_rsp.block_address, out_rsp.status,
                                          out_rsp.free_blocks));
            end else begin
                want = pending_responses.pop_front();
                if (out_rsp.block_address !== want.block_address) begin
                    report_mismatch($sformatf("block_address %h, predicted %h",
                                              out_rsp.block_address, want.block_address));
                end
                if (out_rsp.status !== want.status) begin
                    report_mismatch($sformatf("status %0d, predicted %0d",
                                              out_rsp.status, want.status));
                end
                if (out_rsp.free_blocks !== want.free_blocks) begin
                    report_mismatch($sformatf("free_blocks %0d, predicted %0d",
                                              out_rsp.free_blocks, want.free_blocks));
                end
            end
        end
    end

    // Receiver back-pressure: the stall rate changes from phase to phase,
    // one of the rates being no stall at all.
    always @(posedge clk) begin
        if (style_left == 0) begin
            case ($urandom_range(0, 3))
                0: begin
                    stall_pct = 0;
                end
                1: begin
                    stall_pct = 10;
                end
                2: begin
                    stall_pct = 40;
                end
                default: begin
                    stall_pct = 75;
                end
            endcase
            style_left = $urandom_range(50, 500);
        end else begin
            style_left--;
        end
        if (stall_left > 0) begin
            out_ready <= 1'b0;
            stall_left--;
        end else begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 99) < stall_pct) begin
                stall_left = $urandom_range(1, MAX_STALL);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic logic [31:0] region_address();
        return (32'($urandom_range(0, ACTIVE_BLOCKS - 1)) << BLOCK_BYTES_LOG2)
               | 32'($urandom_range(0, BLOCK_BYTES - 1));
    endfunction

    // Often under one block, so that the rounding of both range kinds shows.
    function automatic logic [31:0] short_length();
        if ($urandom_range(0, 3) == 0) begin
            return $urandom_range(0, BLOCK_BYTES - 1);
        end
        return $urandom_range(0, 48 * BLOCK_BYTES);
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Straight after reset nothing is free, so allocation must report
    // exhaustion; block 0 may be freed like any other and handed out again.
    task automatic test_exhaustion();
        send_request(KIND_ALLOC, $urandom(), $urandom());
        send_request(KIND_FREE, 32'h0000_0abc, 32'h0);
        send_request(KIND_ALLOC, 32'hffff_ffff, 32'hffff_ffff);
        send_request(KIND_ALLOC, 32'h0, 32'h0);
    endtask

    // Frees past the last block and double frees are refused and leave the
    // state alone; the last block itself is a legal free.
    task automatic test_bad_frees();
        send_request(KIND_FREE, 32'(NUM_BLOCKS) << BLOCK_BYTES_LOG2, 32'h0);
        send_request(KIND_FREE, 32'hffff_ffff, 32'hffff_ffff);
        send_request(KIND_FREE, 32'h0000_5000, 32'h0);
        send_request(KIND_FREE, 32'h0000_5fff, 32'h0);
        send_request(KIND_FREE, 32'(NUM_BLOCKS - 1) << BLOCK_BYTES_LOG2, 32'h0);
        send_request(KIND_ALLOC, 32'h0, 32'h0);
    endtask

    // Rounding of both range kinds, zero lengths, blocks already in the
    // target state, and ranges that start near or past the end.
    task automatic test_range_rounding();
        send_request(KIND_RESERVE, 32'h0000_7000, 32'h0);
        send_request(KIND_RELEASE, 32'h0, 32'h0);
        send_request(KIND_RELEASE, 32'h0000_1123, 32'h0000_3fff);
        send_request(KIND_RESERVE, 32'h0000_2000, 32'h0000_0001);
        send_request(KIND_RELEASE, 32'h0000_1000, 32'h0000_2000);
        send_request(KIND_RESERVE, 32'(NUM_BLOCKS - 2) << BLOCK_BYTES_LOG2, 32'h0001_0000);
        send_request(KIND_RELEASE, 32'hffff_f000, 32'hffff_ffff);
        send_request(KIND_RESERVE, 32'h0000_0fff, 32'h0000_1002);
        send_request(KIND_ALLOC, 32'h0, 32'h0);
    endtask

    // Whole-map release, the count at its very top once block 0 is freed,
    // then a whole-map reserve back to nothing free.
    task automatic test_full_span();
        send_request(KIND_RELEASE, 32'h0, 32'hffff_ffff);
        send_request(KIND_FREE, 32'h0, 32'h0);
        send_request(KIND_ALLOC, 32'h0, 32'h0);
        send_request(KIND_RELEASE, 32'h0000_1000, 32'h0000_1000);
        send_request(KIND_RESERVE, 32'h0, 32'hffff_ffff);
    endtask

    // Mixed traffic: mostly well-formed release/allocate/free cycles in the
    // low blocks, with reserves, refused frees, raw noise and a few ranges
    // over the whole map. Halfway through the sender waits for a full drain.
    task automatic test_random_traffic();
        int unsigned start_count;
        int unsigned pick;
        int unsigned n;
        int unsigned idx;
        logic [31:0] addr;
        bit          paused;

        start_count = items_sent;
        paused      = 1'b0;
        while (items_sent - start_count < RANDOM_ITEMS) begin
            if (!paused && items_sent - start_count >= RANDOM_ITEMS / 2) begin
                wait_for_responses();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                send_request(KIND_RELEASE, region_address(), short_length());
            end else if (pick < 45) begin
                n = $urandom_range(1, 6);
                repeat (n) begin
                    send_request(KIND_ALLOC, $urandom(), $urandom());
                    if (last_outcome.status == ST_OK) begin
                        allocated_addrs.push_back(last_outcome.block_address);
                    end
                end
            end else if (pick < 70) begin
                if (allocated_addrs.size() != 0) begin
                    idx  = $urandom_range(0, allocated_addrs.size() - 1);
                    addr = allocated_addrs[idx] | 32'($urandom_range(0, BLOCK_BYTES - 1));
                    allocated_addrs.delete(idx);
                    send_request(KIND_FREE, addr, $urandom());
                    // The same block again is a double free.
                    if ($urandom_range(0, 4) == 0) begin
                        send_request(KIND_FREE, addr, $urandom());
                    end
                end else begin
                    send_request(KIND_FREE, region_address(), $urandom());
                end
            end else if (pick < 82) begin
                send_request(KIND_RESERVE, region_address(), short_length());
            end else if (pick < 85) begin
                send_request(KIND_FREE, $urandom() | (32'(NUM_BLOCKS) << BLOCK_BYTES_LOG2),
                             $urandom());
            end else if (pick < 98) begin
                send_request(t_kind'($urandom_range(0, 3)), $urandom(), $urandom());
            end else begin
                case ($urandom_range(0, 3))
                    0: begin
                        send_request(KIND_RELEASE, $urandom_range(0, BLOCK_BYTES - 1),
                                     32'hffff_ffff);
                    end
                    1: begin
                        send_request(KIND_RESERVE, $urandom_range(0, BLOCK_BYTES - 1),
                                     32'hffff_ffff);
                    end
                    2: begin
                        send_request(KIND_RESERVE, region_address(), $urandom());
                    end
                    default: begin
                        send_request(KIND_RELEASE, region_address(), $urandom());
                    end
                endcase
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Run
    // ------------------------------------------------------------------

    initial begin
        for (cycle_count = 0; cycle_count < LIMIT_CYCLES; cycle_count++) begin
            @(posedge clk);
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        foreach (shadow_map[w]) begin
            shadow_map[w] = '1;
        end
        shadow_free = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // The clearing pass after reset simply shows up as a long wait for
        // the first acceptance.
        test_exhaustion();
        test_bad_frees();
        test_range_rounding();
        test_full_span();
        test_random_traffic();

        wait_for_responses();
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (pending_responses.size() != 0) begin
            void'(pending_responses.pop_front());
            report_mismatch("predicted response never arrived");
        end

        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/bba_pkg.sv
hw/rtl/bba_bitmap_ram.sv
hw/rtl/bba_word_unit.sv
hw/rtl/bitmap_block_allocator.sv
hw/rtl/bba_checker.sv
sim/testbench.sv
